@@ design/sck_pkg.sv @@
// Shared types and constants for the sort-and-count block.
// Depends on nothing; the top level and the testbench use it by scoped names.
`default_nettype none
package sck_pkg;
  localparam int unsigned CountW = 7;
  localparam logic [CountW-1:0] MinCountReset = 7'd5;

  typedef enum logic [6:0] {
    StLoad  = 7'b0000001,
    StSortR = 7'b0000010,
    StSortC = 7'b0000100,
    StScanR = 7'b0001000,
    StScanC = 7'b0010000,
    StEmit  = 7'b0100000,
    StFlush = 7'b1000000
  } state_e;
endpackage
`default_nettype wire

@@ design/sck_if.sv @@
// Valid/ready channel interfaces for keys and results.
// Depends on nothing.
`default_nettype none
interface sck_key_if #(
  parameter int unsigned KeyW = 64
);
  logic            valid;
  logic            ready;
  logic [KeyW-1:0] key;
  logic            last;
  modport source (output valid, key, last, input ready);
  modport sink (input valid, key, last, output ready);
endinterface

interface sck_res_if #(
  parameter int unsigned KeyW = 64
);
  logic            valid;
  logic            ready;
  logic [KeyW-1:0] key_res;
  logic [6:0]      run_length;
  logic [6:0]      kept_so_far;
  logic            empty_res;
  logic            overflow;
  logic            last_res;
  modport source (output valid, key_res, run_length, kept_so_far, empty_res, overflow,
    last_res, input ready);
  modport sink (input valid, key_res, run_length, kept_so_far, empty_res, overflow,
    last_res, output ready);
endinterface
`default_nettype wire

@@ design/sck_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
`default_nettype none
module sck_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

@@ design/sort_and_count_repeated_keys.sv @@
// Top level: loads keys into a RAM, sorts them in place and reports runs.
// After loading, an insertion sort places each key by shifting the larger keys up one slot,
// and a scan over the sorted store then counts the runs of equal keys.
// Each report waits until the next kept run closes or the set ends, and leaves through a one-entry output register.
// Throughput: one key per cycle during loading, sets are processed one at a time.
// Reset clears the control state and sets min_count to 5; the RAM is not cleared.
// Depends on sck_pkg, sck_if and sck_ram.
`default_nettype none
module sort_and_count_repeated_keys #(
  parameter int unsigned MaxKeys = 64,
  parameter int unsigned KeyBits = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  sck_key_if.sink         key_in,
  sck_res_if.source       res_out
);
  localparam int unsigned AW = $clog2(MaxKeys);
  localparam int unsigned CW = sck_pkg::CountW;
  localparam logic [CW-1:0] MaxCnt = CW'(MaxKeys);

  sck_pkg::state_e state_q, state_d;
  logic [CW-1:0]      fill_q, fill_d, i_q, i_d, j_q, j_d, run_q, run_d, kept_q, kept_d;
  logic [CW-1:0]      min_q;
  logic               ovf_q, ovf_d;
  logic [KeyBits-1:0] v_q, v_d, cur_q, cur_d;
  logic               pend_q, pend_d;
  logic [KeyBits-1:0] pkey_q, pkey_d;
  logic [CW-1:0]      plen_q, plen_d;
  logic               ov_q, ov_d;
  logic [KeyBits-1:0] okey_q, okey_d;
  logic [CW-1:0]      olen_q, olen_d, okept_q, okept_d;
  logic               oempty_q, oempty_d, oovf_q, oovf_d, olast_q, olast_d;

  logic               we;
  logic [AW-1:0]      addr;
  logic [KeyBits-1:0] wdata, rdata;

  sck_ram #(.Width(KeyBits), .Depth(MaxKeys)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= sck_pkg::MinCountReset;
    end else if (cfg_we_i) begin
      min_q <= cfg_wdata_i;
    end
  end

  assign key_in.ready = (state_q == sck_pkg::StLoad);
  assign res_out.valid = ov_q;
  assign res_out.key_res = okey_q;
  assign res_out.run_length = olen_q;
  assign res_out.kept_so_far = okept_q;
  assign res_out.empty_res = oempty_q;
  assign res_out.overflow = oovf_q;
  assign res_out.last_res = olast_q;

  always_comb begin
    state_d = state_q;
    fill_d = fill_q; i_d = i_q; j_d = j_q; run_d = run_q; kept_d = kept_q;
    ovf_d = ovf_q; v_d = v_q; cur_d = cur_q;
    pend_d = pend_q; pkey_d = pkey_q; plen_d = plen_q;
    ov_d = ov_q && !res_out.ready;
    okey_d = okey_q; olen_d = olen_q; okept_d = okept_q;
    oempty_d = oempty_q; oovf_d = oovf_q; olast_d = olast_q;
    we = 1'b0; addr = '0; wdata = key_in.key[KeyBits-1:0];
    case (state_q)
      sck_pkg::StLoad: begin
        addr = fill_q[AW-1:0];
        if (key_in.valid) begin
          if (fill_q < MaxCnt) begin
            we = 1'b1;
            fill_d = fill_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (key_in.last) begin
            i_d = CW'(1);
            state_d = sck_pkg::StSortR;
          end
        end
      end
      sck_pkg::StSortR: begin
        // Read key i into v; j walks down from i.
        if (i_q >= fill_q) begin
          i_d = '0; run_d = '0; kept_d = '0;
          state_d = sck_pkg::StScanR;
        end else begin
          addr = i_q[AW-1:0];
          j_d = i_q;
          state_d = sck_pkg::StSortC;
          run_d = '0;
        end
      end
      sck_pkg::StSortC: begin
        // run_q is 0 when rdata is v, 2 when store[j-1] must be fetched, else rdata is store[j-1].
        if (run_q == '0) begin
          v_d = rdata;
          run_d = CW'(1);
          addr = AW'(j_q - CW'(1));
        end else if (run_q == CW'(2)) begin
          addr = AW'(j_q - CW'(1));
          run_d = CW'(1);
        end else if (rdata > v_q) begin
          we = 1'b1; addr = j_q[AW-1:0]; wdata = rdata;
          j_d = j_q - CW'(1);
          run_d = CW'(2);
          if (j_q == CW'(1)) begin
            state_d = sck_pkg::StEmit;
          end
        end else begin
          we = 1'b1; addr = j_q[AW-1:0]; wdata = v_q;
          i_d = i_q + CW'(1);
          state_d = sck_pkg::StSortR;
        end
      end
      sck_pkg::StEmit: begin
        // Shifted down to slot 0: place v there.
        we = 1'b1; addr = '0; wdata = v_q;
        i_d = i_q + CW'(1);
        state_d = sck_pkg::StSortR;
      end
      sck_pkg::StScanR: begin
        addr = i_q[AW-1:0];
        if (i_q >= fill_q) begin
          state_d = sck_pkg::StFlush;
        end else begin
          state_d = sck_pkg::StScanC;
        end
      end
      sck_pkg::StScanC: begin
        addr = i_q[AW-1:0];
        if (!ov_d) begin
          if (run_q != '0 && rdata == cur_q) begin
            run_d = run_q + CW'(1);
          end else begin
            if (run_q != '0 && run_q >= min_q) begin
              if (pend_q) begin
                ov_d = 1'b1; okey_d = pkey_q; olen_d = plen_q; okept_d = kept_q;
                oempty_d = 1'b0; oovf_d = ovf_q; olast_d = 1'b0;
              end
              pend_d = 1'b1; pkey_d = cur_q; plen_d = run_q;
              kept_d = kept_q + CW'(1);
            end
            cur_d = rdata;
            run_d = CW'(1);
          end
          i_d = i_q + CW'(1);
          state_d = sck_pkg::StScanR;
        end
      end
      sck_pkg::StFlush: begin
        if (!ov_d) begin
          if (run_q != '0 && run_q >= min_q) begin
            if (pend_q) begin
              ov_d = 1'b1; okey_d = pkey_q; olen_d = plen_q; okept_d = kept_q;
              oempty_d = 1'b0; oovf_d = ovf_q; olast_d = 1'b0;
            end
            pend_d = 1'b1; pkey_d = cur_q; plen_d = run_q;
            kept_d = kept_q + CW'(1);
            run_d = '0;
          end else begin
            ov_d = 1'b1; oovf_d = ovf_q; olast_d = 1'b1;
            if (pend_q) begin
              okey_d = pkey_q; olen_d = plen_q; okept_d = kept_q; oempty_d = 1'b0;
            end else begin
              okey_d = '0; olen_d = '0; okept_d = '0; oempty_d = 1'b1;
            end
            pend_d = 1'b0; fill_d = '0; ovf_d = 1'b0;
            state_d = sck_pkg::StLoad;
          end
        end
      end
      default: state_d = sck_pkg::StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sck_pkg::StLoad;
      fill_q <= '0; i_q <= '0; j_q <= '0; run_q <= '0; kept_q <= '0;
      ovf_q <= 1'b0; ov_q <= 1'b0; pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d; i_q <= i_d; j_q <= j_d; run_q <= run_d; kept_q <= kept_d;
      ovf_q <= ovf_d; ov_q <= ov_d; pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d; cur_q <= cur_d;
    pkey_q <= pkey_d; plen_q <= plen_d;
    okey_q <= okey_d; olen_q <= olen_d; okept_q <= okept_d;
    oempty_q <= oempty_d; oovf_q <= oovf_d; olast_q <= olast_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= MaxCnt) else $error("fill count beyond store depth");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !res_out.ready |=> ov_q && $stable(okey_q)) else $error("result lost");
  a_noload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != sck_pkg::StLoad |-> !key_in.ready) else $error("ready while busy");
endmodule
`default_nettype wire

@@ tb/sv/sort_and_count_repeated_keys_test.sv @@
// Self-checking testbench for sort_and_count_repeated_keys: sends key sets, predicts
// the sorted run reports with threshold and overflow, and compares every result item.
// Depends on sck_pkg, sck_if and the design top level.
`default_nettype none
module sort_and_count_repeated_keys_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxKeys = 64;
  localparam int unsigned WatchLimit = 200000;

  typedef struct packed {
    logic [63:0] key_res;
    logic [6:0]  run_length;
    logic [6:0]  kept_so_far;
    logic        empty_res;
    logic        overflow;
    logic        last_res;
  } run_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [6:0] cfg_wdata_i = '0;

  sck_key_if #(.KeyW(64)) key_ch ();
  sck_res_if #(.KeyW(64)) res_ch ();

  sort_and_count_repeated_keys #(.MaxKeys(MaxKeys), .KeyBits(64)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .key_in(key_ch.sink), .res_out(res_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [63:0] set_keys[$];
  logic        set_overflow;
  logic [6:0]  min_count;
  run_report_t expected_reports[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_cycles = 0;
  bit          stall_enable = 1'b1;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Sorts the collected set, groups equal keys and queues the reports it causes.
  function automatic void predict_runs();
    logic [63:0] sorted[$];
    run_report_t rep;
    int unsigned pos;
    int unsigned len;
    int unsigned kept;
    logic [63:0] cur;
    sorted = set_keys;
    sorted.sort();
    pos = 0;
    kept = 0;
    while (pos < sorted.size()) begin
      cur = sorted[pos];
      len = 0;
      while (pos < sorted.size() && sorted[pos] == cur) begin
        len++;
        pos++;
      end
      if (len >= min_count) begin
        kept++;
        rep = '0;
        rep.key_res = cur;
        rep.run_length = len[6:0];
        rep.kept_so_far = kept[6:0];
        rep.overflow = set_overflow;
        expected_reports = {expected_reports, rep};
      end
    end
    if (kept == 0) begin
      rep = '0;
      rep.empty_res = 1'b1;
      rep.overflow = set_overflow;
      rep.last_res = 1'b1;
      expected_reports = {expected_reports, rep};
    end else begin
      expected_reports[expected_reports.size()-1].last_res = 1'b1;
    end
    set_keys.delete();
    set_overflow = 1'b0;
  endfunction

  task automatic send_key(input logic [63:0] key, input logic last);
    key_ch.valid <= 1'b1;
    key_ch.key <= key;
    key_ch.last <= last;
    do @(posedge clk_i); while (!key_ch.ready);
    if (set_keys.size() < MaxKeys) set_keys = {set_keys, key};
    else set_overflow = 1'b1;
    if (last) predict_runs();
  endtask

  task automatic pause_sender();
    key_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic drain();
    key_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_min_count(input logic [6:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    min_count = value;
  endtask

  // Sends a set of n keys drawn from a pool of the given size, in random bursts if bursty is set.
  task automatic send_set(input int unsigned n, input int unsigned pool, input bit bursty);
    logic [63:0] vals[8];
    int unsigned burst;
    foreach (vals[i]) vals[i] = {$urandom, $urandom};
    burst = $urandom_range(1, 12);
    for (int unsigned i = 0; i < n; i++) begin
      if (bursty && burst == 0) begin
        pause_sender();
        burst = $urandom_range(1, 12);
      end
      send_key(vals[$urandom_range(0, pool - 1)], i == n - 1);
      if (burst != 0) burst--;
    end
  endtask

  task automatic test_directed_extremes();
    send_key(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_key(64'h0, 1'b0);
    send_key(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_key(64'h0, 1'b0);
    send_key(64'h8000_0000_0000_0001, 1'b0);
    send_key(64'h0, 1'b0);
    send_key(64'h0, 1'b0);
    send_key(64'h0, 1'b1);
  endtask

  task automatic test_threshold_settings();
    write_min_count(7'd0);
    send_set(6, 3, 1'b0);
    write_min_count(7'd1);
    send_set(5, 5, 1'b0);
    write_min_count(7'd64);
    send_set(64, 1, 1'b0);
    write_min_count(7'd127);
    send_set(3, 1, 1'b0);
    write_min_count(7'd2);
  endtask

  task automatic test_overflow();
    send_set(66, 2, 1'b0);
    for (int unsigned i = 0; i < 64; i++) send_key({$urandom, $urandom}, 1'b0);
    send_key(64'h1234, 1'b1);
  endtask

  task automatic test_backpressure();
    drain();
    hold_cycles = 2000;
    send_set(40, 1, 1'b0);
    send_set(30, 8, 1'b0);
    send_set(20, 4, 1'b0);
    drain();
  endtask

  task automatic test_random_sets();
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < 180) begin
      if ($urandom_range(0, 9) == 0) write_min_count(7'($urandom_range(0, 6)));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 14);
      send_set(n, $urandom_range(1, 8), $urandom_range(0, 3) != 0);
      sent += n;
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      res_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (stall_enable) begin
      res_ch.ready <= ($urandom_range(0, 15) > 4) || (($time / 10) % 97 < 30);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    run_report_t got;
    run_report_t exp_rep;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = {res_ch.key_res, res_ch.run_length, res_ch.kept_so_far, res_ch.empty_res,
             res_ch.overflow, res_ch.last_res};
      if (expected_reports.size() == 0) begin
        report_mismatch("result with no expectation");
      end else begin
        exp_rep = expected_reports.pop_front();
        if (got.key_res !== exp_rep.key_res)
          report_mismatch($sformatf("key_res %h exp %h", got.key_res, exp_rep.key_res));
        if (got.run_length !== exp_rep.run_length)
          report_mismatch($sformatf("run_length %0d exp %0d", got.run_length,
            exp_rep.run_length));
        if (got.kept_so_far !== exp_rep.kept_so_far)
          report_mismatch($sformatf("kept_so_far %0d exp %0d", got.kept_so_far,
            exp_rep.kept_so_far));
        if (got.empty_res !== exp_rep.empty_res) report_mismatch("empty_res");
        if (got.overflow !== exp_rep.overflow) report_mismatch("overflow");
        if (got.last_res !== exp_rep.last_res) report_mismatch("last_res");
      end
    end
  end

  always @(posedge clk_i) begin
    if ((key_ch.valid && key_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    key_ch.valid = 1'b0;
    key_ch.key = '0;
    key_ch.last = 1'b0;
    res_ch.ready = 1'b0;
    set_overflow = 1'b0;
    min_count = sck_pkg::MinCountReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_threshold_settings();
    test_overflow();
    test_backpressure();
    test_random_sets();
    drain();
    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
design/sck_pkg.sv
design/sck_if.sv
design/sck_ram.sv
design/sort_and_count_repeated_keys.sv
tb/sv/sort_and_count_repeated_keys_test.sv
